// ===== rtl/i2cmts_pkg.sv =====
package i2cmts_pkg;

  // send buffer geometry
  localparam int BUF_DEPTH = 32;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = 6;
  localparam int LEN_MAX   = (BUF_DEPTH < 63) ? BUF_DEPTH : 63;
  localparam int RXPOS_W   = 5;

  // kind of input word
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // sequencer phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_RECV1 = 3'd3,
    PH_RECV2 = 3'd4,
    PH_RECVN = 3'd5,
    PH_SEND  = 3'd6,
    PH_STOP  = 3'd7
  } phase_t;

  // ack / pos control action
  typedef enum logic [1:0] {
    ACT_KEEP  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  // one input word
  typedef struct packed {
    logic [1:0]       mode;
    logic [4:0]       load_index;
    logic [7:0]       load_byte;
    logic [LEN_W-1:0] send_count;
    logic [LEN_W-1:0] recv_count;
    logic             start_done;
    logic             addr_done;
    logic             rx_full;
    logic             byte_finished;
    logic             stop_pending;
    logic [7:0]       dr_first;
    logic [7:0]       dr_second;
  } item_t;

  // one result word
  typedef struct packed {
    logic               issue_start;
    logic               issue_stop;
    act_t               ack_action;
    act_t               pos_action;
    logic               clear_addr;
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic [1:0]         rx_stored;
    logic [RXPOS_W-1:0] rx_position;
    logic [7:0]         rx_byte_a;
    logic [7:0]         rx_byte_b;
    logic               transfer_done;
  } res_t;

  // send buffer write request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  // saturate a requested length to the buffer size
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(LEN_MAX);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ===== rtl/i2cmts_sendbuf.sv =====
module i2cmts_sendbuf #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/i2cmts_ctrl.sv =====
module i2cmts_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  i2cmts_pkg::item_t             item,
  input  logic [7:0]                    target_addr,
  input  logic [7:0]                    buf_rd_data,
  output logic [i2cmts_pkg::IDX_W-1:0]  buf_rd_addr,
  output i2cmts_pkg::buf_wr_t           buf_wr,
  output i2cmts_pkg::res_t              res
);

  localparam int LW = i2cmts_pkg::LEN_W;

  i2cmts_pkg::phase_t phase_r, phase_nxt;
  logic               reading_r, reading_nxt;
  logic [LW-1:0]      pos_r, pos_nxt;
  logic [LW-1:0]      wr_len_r, wr_len_nxt;
  logic [LW-1:0]      rd_len_r, rd_len_nxt;
  logic [LW-1:0]      req_wl, req_rl;
  logic [LW-1:0]      left;
  logic [7:0]         send_byte;
  logic               load_ok;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cmts_pkg::PH_IDLE;
      reading_r <= 1'b0;
      pos_r     <= '0;
      wr_len_r  <= '0;
      rd_len_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      reading_r <= reading_nxt;
      pos_r     <= pos_nxt;
      wr_len_r  <= wr_len_nxt;
      rd_len_r  <= rd_len_nxt;
    end
  end

  // send buffer access: read address follows the next position, so the
  // registered read data always holds the entry at pos_r
  assign buf_rd_addr = i2cmts_pkg::IDX_W'(pos_nxt);
  assign send_byte   = (32'(pos_r) < i2cmts_pkg::BUF_DEPTH) ? buf_rd_data : 8'd0;
  assign load_ok     = 32'(item.load_index) < i2cmts_pkg::BUF_DEPTH;
  assign req_wl      = i2cmts_pkg::clamp_len(item.send_count);
  assign req_rl      = i2cmts_pkg::clamp_len(item.recv_count);
  assign left        = (rd_len_r > pos_r) ? (rd_len_r - pos_r) : '0;

  // next state and result
  always_comb begin
    phase_nxt   = phase_r;
    reading_nxt = reading_r;
    pos_nxt     = pos_r;
    wr_len_nxt  = wr_len_r;
    rd_len_nxt  = rd_len_r;
    res         = '0;
    buf_wr.we   = 1'b0;
    buf_wr.addr = i2cmts_pkg::IDX_W'(item.load_index);
    buf_wr.data = item.load_byte;
    if (step) begin
      case (i2cmts_pkg::mode_t'(item.mode))
        i2cmts_pkg::MODE_LOAD: begin
          if (phase_r == i2cmts_pkg::PH_IDLE && load_ok) begin
            buf_wr.we = 1'b1;
          end
        end
        i2cmts_pkg::MODE_START: begin
          if (phase_r == i2cmts_pkg::PH_IDLE) begin
            wr_len_nxt = req_wl;
            rd_len_nxt = req_rl;
            if (req_wl == '0 && req_rl == '0) begin
              res.transfer_done = 1'b1;
            end else begin
              reading_nxt     = (req_wl == '0);
              pos_nxt         = '0;
              res.issue_start = 1'b1;
              phase_nxt       = i2cmts_pkg::PH_START;
            end
          end
        end
        i2cmts_pkg::MODE_TICK: begin
          case (phase_r)
            i2cmts_pkg::PH_START: begin
              if (item.start_done) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = {target_addr[7:1], reading_r};
                phase_nxt    = i2cmts_pkg::PH_ADDR;
              end
            end
            i2cmts_pkg::PH_ADDR: begin
              if (item.addr_done) begin
                res.clear_addr = 1'b1;
                if (reading_r) begin
                  if (rd_len_r == LW'(1)) begin
                    res.issue_stop = 1'b1;
                    phase_nxt      = i2cmts_pkg::PH_RECV1;
                  end else if (rd_len_r == LW'(2)) begin
                    res.pos_action = i2cmts_pkg::ACT_SET;
                    phase_nxt      = i2cmts_pkg::PH_RECV2;
                  end else begin
                    res.ack_action = i2cmts_pkg::ACT_SET;
                    phase_nxt      = i2cmts_pkg::PH_RECVN;
                  end
                end else begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = send_byte;
                  pos_nxt      = pos_r + LW'(1);
                  phase_nxt    = i2cmts_pkg::PH_SEND;
                end
              end
            end
            i2cmts_pkg::PH_RECV1: begin
              if (item.rx_full) begin
                res.rx_stored   = 2'd1;
                res.rx_position = pos_r[i2cmts_pkg::RXPOS_W-1:0];
                res.rx_byte_a   = item.dr_first;
                pos_nxt         = pos_r + LW'(1);
                phase_nxt       = i2cmts_pkg::PH_STOP;
              end
            end
            i2cmts_pkg::PH_RECV2: begin
              if (item.byte_finished) begin
                res.ack_action  = i2cmts_pkg::ACT_CLEAR;
                res.pos_action  = i2cmts_pkg::ACT_CLEAR;
                res.issue_stop  = 1'b1;
                res.rx_stored   = 2'd2;
                res.rx_position = pos_r[i2cmts_pkg::RXPOS_W-1:0];
                res.rx_byte_a   = item.dr_first;
                res.rx_byte_b   = item.dr_second;
                pos_nxt         = pos_r + LW'(2);
                phase_nxt       = i2cmts_pkg::PH_STOP;
              end
            end
            i2cmts_pkg::PH_RECVN: begin
              if (item.byte_finished) begin
                res.rx_position = pos_r[i2cmts_pkg::RXPOS_W-1:0];
                res.rx_byte_a   = item.dr_first;
                if (left > LW'(3)) begin
                  res.rx_stored = 2'd1;
                  pos_nxt       = pos_r + LW'(1);
                end else if (left == LW'(3)) begin
                  res.ack_action = i2cmts_pkg::ACT_CLEAR;
                  res.rx_stored  = 2'd1;
                  pos_nxt        = pos_r + LW'(1);
                end else begin
                  // last two bytes arrive together
                  res.ack_action = i2cmts_pkg::ACT_CLEAR;
                  res.pos_action = i2cmts_pkg::ACT_CLEAR;
                  res.issue_stop = 1'b1;
                  res.rx_stored  = 2'd2;
                  res.rx_byte_b  = item.dr_second;
                  pos_nxt        = pos_r + LW'(2);
                  phase_nxt      = i2cmts_pkg::PH_STOP;
                end
              end
            end
            i2cmts_pkg::PH_SEND: begin
              if (item.byte_finished) begin
                if (pos_r < wr_len_r) begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = send_byte;
                  pos_nxt      = pos_r + LW'(1);
                end else begin
                  res.issue_stop = 1'b1;
                  phase_nxt      = i2cmts_pkg::PH_STOP;
                end
              end
            end
            i2cmts_pkg::PH_STOP: begin
              if (!item.stop_pending) begin
                if (rd_len_r != '0 && !reading_r) begin
                  // repeated start into the read phase
                  reading_nxt     = 1'b1;
                  pos_nxt         = '0;
                  res.issue_start = 1'b1;
                  phase_nxt       = i2cmts_pkg::PH_START;
                end else begin
                  res.transfer_done = 1'b1;
                  reading_nxt       = 1'b0;
                  phase_nxt         = i2cmts_pkg::PH_IDLE;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// I2C master write-then-read transfer sequencer over a byte-level controller.
// Input channel (in_valid/in_ready): one word per cycle while in_ready is
// high; in_mode selects a send buffer load, a transfer request or a controller
// status tick. Loads and requests are ignored while a transfer is running.
// Result channel (out_valid/out_ready): exactly one result word per input
// word, in order, carrying the controller actions (start, stop, ack/pos,
// address clear, data register write), received bytes and transfer_done.
// Configuration: cfg_wr_en writes cfg_wr_data into the peer address register
// in that cycle; write it only while no word is in flight.
// Path: an accepted word is held in the input register, the state update turns
// it into a result word, and that word loads the result register, which
// raises out_valid. Throughput: one word per cycle while the receiver keeps
// out_ready high.
// Reset (rst_n low, synchronous): sequencer returns to idle, lengths and
// position clear, peer address clears; the send buffer is not cleared.
// When the receiver stalls, the held result and the word behind it stay put
// and in_ready drops once both registers are full.
module i2c_master_transfer_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [4:0] in_load_index,
  input  logic [7:0] in_load_byte,
  input  logic [5:0] in_send_count,
  input  logic [5:0] in_recv_count,
  input  logic       in_start_done,
  input  logic       in_addr_done,
  input  logic       in_rx_full,
  input  logic       in_byte_finished,
  input  logic       in_stop_pending,
  input  logic [7:0] in_dr_first,
  input  logic [7:0] in_dr_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_issue_start,
  output logic       out_issue_stop,
  output logic [1:0] out_ack_action,
  output logic [1:0] out_pos_action,
  output logic       out_clear_addr,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic [1:0] out_rx_stored,
  output logic [4:0] out_rx_position,
  output logic [7:0] out_rx_byte_a,
  output logic [7:0] out_rx_byte_b,
  output logic       out_transfer_done
);

  logic [7:0]                    target_addr_r;
  logic                          s1_valid_r;
  i2cmts_pkg::item_t             s1_item_r;
  logic                          out_valid_r;
  i2cmts_pkg::res_t              out_res_r;
  i2cmts_pkg::res_t              res;
  i2cmts_pkg::buf_wr_t           buf_wr;
  logic [i2cmts_pkg::IDX_W-1:0]  buf_rd_addr;
  logic [7:0]                    buf_rd_data;
  logic                          out_free;
  logic                          step;

  // handshake between the stages
  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // peer address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_addr_r <= 8'd0;
    end else if (cfg_wr_en) begin
      target_addr_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= '{mode: in_mode, load_index: in_load_index, load_byte: in_load_byte,
                     send_count: in_send_count, recv_count: in_recv_count,
                     start_done: in_start_done, addr_done: in_addr_done,
                     rx_full: in_rx_full, byte_finished: in_byte_finished,
                     stop_pending: in_stop_pending, dr_first: in_dr_first,
                     dr_second: in_dr_second};
    end
  end

  i2cmts_sendbuf #(
    .WIDTH (8),
    .DEPTH (i2cmts_pkg::BUF_DEPTH)
  ) u_sendbuf (
    .clk     (clk),
    .wr_en   (buf_wr.we),
    .wr_addr (buf_wr.addr),
    .wr_data (buf_wr.data),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  i2cmts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (s1_item_r),
    .target_addr (target_addr_r),
    .buf_rd_data (buf_rd_data),
    .buf_rd_addr (buf_rd_addr),
    .buf_wr      (buf_wr),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_issue_start   = out_res_r.issue_start;
  assign out_issue_stop    = out_res_r.issue_stop;
  assign out_ack_action    = out_res_r.ack_action;
  assign out_pos_action    = out_res_r.pos_action;
  assign out_clear_addr    = out_res_r.clear_addr;
  assign out_tx_valid      = out_res_r.tx_valid;
  assign out_tx_byte       = out_res_r.tx_byte;
  assign out_rx_stored     = out_res_r.rx_stored;
  assign out_rx_position   = out_res_r.rx_position;
  assign out_rx_byte_a     = out_res_r.rx_byte_a;
  assign out_rx_byte_b     = out_res_r.rx_byte_b;
  assign out_transfer_done = out_res_r.transfer_done;

endmodule
